// ===== rtl/vgdh_pkg.sv =====
// Package: types and constants shared by the voxel dedup hash core.
package vgdh_pkg;

    localparam int TABLE_SIZE       = 4096;
    localparam int VOXEL_INDEX_BITS = 16;
    localparam int SLOT_BITS        = $clog2(TABLE_SIZE);
    localparam int PROBE_BITS       = SLOT_BITS + 1;
    localparam int ENTRY_BITS       = 3 * VOXEL_INDEX_BITS;
    localparam int COUNT_BITS       = 13;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [31:0] BASE_MULT = 32'h9E37_79B6;
    localparam logic [31:0] STEP_MULT = 32'hB504_F333;
    localparam logic [31:0] DJB_SEED  = 32'd5381;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [7:0] GREY_MAX = 8'd255;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_X         = 3'd0,
        CFG_MIN_Y         = 3'd1,
        CFG_MIN_Z         = 3'd2,
        CFG_INV_RES       = 3'd3,
        CFG_MIN_INTENSITY = 3'd4,
        CFG_INT_GAIN      = 3'd5,
        CFG_GREY_SELECT   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [15:0]        intensity;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } point_in_t;

    typedef struct packed {
        logic signed [31:0] kept_x;
        logic signed [31:0] kept_y;
        logic signed [31:0] kept_z;
        logic [23:0]        packed_colour;
        logic [12:0]        voxels_kept;
    } point_out_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic [31:0]        inv_resolution;
        logic [15:0]        min_intensity;
        logic [31:0]        intensity_gain;
        logic               grey_select;
    } cfg_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    pz;
        logic [23:0]           colour;
        logic [ENTRY_BITS-1:0] voxel;
        logic [SLOT_BITS-1:0]  slot;
        logic [SLOT_BITS-1:0]  step;
    } job_t;

    typedef enum logic [2:0] {
        FS_IDLE, FS_DIFF, FS_MUL, FS_HASH, FS_SLOT, FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_CLEAR, BS_IDLE, BS_READ, BS_CHECK, BS_EMIT
    } back_state_t;

endpackage

// ===== rtl/voxel_grid_dedup_hash_core.sv =====
// Voxel dedup hash core: front classifies points, back probes the table.
// Path: a kept point passes the front states DIFF, MUL, HASH, SLOT and PUSH, the queue, and
// the back states IDLE, READ, CHECK and EMIT; every further probe repeats READ and CHECK.
// Pace: the front takes a new request only after pushing the last; the back spends READ and
// CHECK per probe plus IDLE and EMIT, so it sets the pace only past two probes or under output stalls.
// Reset is asynchronous, active low; configuration returns to its defaults and the table
// clears every slot, during which at most three requests are taken and held.
module voxel_grid_dedup_hash_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  vgdh_pkg::point_in_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output vgdh_pkg::point_out_t                  out_data,
    input  logic                                  cfg_we,
    input  logic [vgdh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vgdh_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import vgdh_pkg::*;

    cfg_t cfg_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x          <= '0;
            cfg_reg.min_y          <= '0;
            cfg_reg.min_z          <= '0;
            cfg_reg.inv_resolution <= 32'd65536;
            cfg_reg.min_intensity  <= '0;
            cfg_reg.intensity_gain <= 32'd65536;
            cfg_reg.grey_select    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_X:         cfg_reg.min_x          <= cfg_data;
                CFG_MIN_Y:         cfg_reg.min_y          <= cfg_data;
                CFG_MIN_Z:         cfg_reg.min_z          <= cfg_data;
                CFG_INV_RES:       cfg_reg.inv_resolution <= cfg_data;
                CFG_MIN_INTENSITY: cfg_reg.min_intensity  <= cfg_data[15:0];
                CFG_INT_GAIN:      cfg_reg.intensity_gain <= cfg_data;
                CFG_GREY_SELECT:   cfg_reg.grey_select    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vgdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    vgdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    vgdh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

// ===== rtl/vgdh_ram.sv =====
// Generic single-port RAM with registered read.
module vgdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one word per cycle; a write returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/vgdh_front.sv =====
// Front: quantize, hash and colour one request, then push it to the queue.
module vgdh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vgdh_pkg::point_in_t in_data,
    input  vgdh_pkg::cfg_t     cfg,
    output logic               job_valid,
    input  logic               job_ready,
    output vgdh_pkg::job_t     job
);
    import vgdh_pkg::*;

    front_state_t state_reg, state_next;
    point_in_t    pt_reg;
    logic [31:0]  diff_reg [3];
    logic         pos_reg [3];
    logic [63:0]  prod_reg [3];
    logic [15:0]  idiff_reg;
    logic [48:0]  gprod_reg;
    logic [31:0]  key_reg;
    logic [31:0]  bfrac, sfrac;
    logic signed [31:0]    px_reg, py_reg, pz_reg;
    logic [23:0]           colour_reg;
    logic [ENTRY_BITS-1:0] voxel_reg;
    logic [SLOT_BITS-1:0]  slot_reg, step_reg;
    logic [7:0]   grey;
    logic [31:0]  hash;
    logic [VOXEL_INDEX_BITS-1:0] idx_c [3];
    logic signed [32:0] mins [3];
    logic signed [32:0] pts [3];

    assign mins[0] = {cfg.min_x[31], cfg.min_x};
    assign mins[1] = {cfg.min_y[31], cfg.min_y};
    assign mins[2] = {cfg.min_z[31], cfg.min_z};
    assign pts[0]  = {pt_reg.point_x[31], pt_reg.point_x};
    assign pts[1]  = {pt_reg.point_y[31], pt_reg.point_y};
    assign pts[2]  = {pt_reg.point_z[31], pt_reg.point_z};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE: if (in_valid) state_next = FS_DIFF;
            FS_DIFF: state_next = FS_MUL;
            FS_MUL:  state_next = FS_HASH;
            FS_HASH: state_next = FS_SLOT;
            FS_SLOT: state_next = FS_PUSH;
            FS_PUSH: if (job_ready) state_next = FS_IDLE;
            default: state_next = FS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready  = (state_reg == FS_IDLE);
        job_valid = (state_reg == FS_PUSH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Clamp the scaled differences to voxel indices
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!pos_reg[i])
                idx_c[i] = '0;
            else if (prod_reg[i][63:32] > 32'({VOXEL_INDEX_BITS{1'b1}}))
                idx_c[i] = {VOXEL_INDEX_BITS{1'b1}};
            else
                idx_c[i] = prod_reg[i][VOXEL_INDEX_BITS+31:32];
        end
    end

    // djb2 mix and absolute value
    always_comb
    begin
        hash = DJB_SEED;
        for (int i = 0; i < 3; i++)
        begin
            hash = (hash << 5) + hash + 32'(idx_c[i]);
        end
        if (hash[31])
            hash = 32'(0) - hash;
    end

    // Fractional parts of the start and step hashes
    assign bfrac = key_reg * BASE_MULT;
    assign sfrac = key_reg * STEP_MULT;

    // Grey level from intensity
    always_comb
    begin
        if (gprod_reg[48:16] > 33'(GREY_MAX))
            grey = GREY_MAX;
        else
            grey = gprod_reg[23:16];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FS_IDLE:
            begin
                if (in_valid)
                    pt_reg <= in_data;
            end
            FS_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    diff_reg[i] <= 32'(pts[i] - mins[i]);
                    pos_reg[i]  <= (pts[i] > mins[i]);
                end
                if (pt_reg.intensity > cfg.min_intensity)
                    idiff_reg <= pt_reg.intensity - cfg.min_intensity;
                else
                    idiff_reg <= '0;
            end
            FS_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i] <= 64'(diff_reg[i]) * 64'(cfg.inv_resolution);
                end
                gprod_reg <= 49'(idiff_reg) * 49'(cfg.intensity_gain);
            end
            FS_HASH:
            begin
                key_reg   <= hash;
                voxel_reg <= {idx_c[0], idx_c[1], idx_c[2]};
                px_reg    <= pt_reg.point_x;
                py_reg    <= pt_reg.point_y;
                pz_reg    <= pt_reg.point_z;
                if (cfg.grey_select)
                    colour_reg <= {grey, grey, grey};
                else
                    colour_reg <= {pt_reg.red_in, pt_reg.green_in, pt_reg.blue_in};
            end
            FS_SLOT:
            begin
                slot_reg <= bfrac[31:32-SLOT_BITS];
                step_reg <= sfrac[31:32-SLOT_BITS] | SLOT_BITS'(1);
            end
            FS_PUSH: ;
            default: ;
        endcase
    end

    // Assemble the outgoing request
    always_comb
    begin
        job.px     = px_reg;
        job.py     = py_reg;
        job.pz     = pz_reg;
        job.colour = colour_reg;
        job.voxel  = voxel_reg;
        job.slot   = slot_reg;
        job.step   = step_reg;
    end

    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("front job changed while stalled");
    a_one_hot_hs: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && job_valid))
        else $error("front accepting while pushing");
    a_push_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(job_valid) |-> $past(state_reg) == FS_SLOT)
        else $error("push without hashing");
endmodule

// ===== rtl/vgdh_queue.sv =====
// Short queue of classified requests between front and back.
module vgdh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  vgdh_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vgdh_pkg::job_t pop_data
);
    import vgdh_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    job_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [PTR_BITS:0]   cnt_reg;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != (PTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_reg];

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count mismatch");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == (PTR_BITS+1)'(QUEUE_DEPTH)) |-> wr_reg == rd_reg)
        else $error("queue pointers out of step");
endmodule

// ===== rtl/vgdh_back.sv =====
// Back: clear the table, probe it, store new voxels and emit results.
module vgdh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  vgdh_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output vgdh_pkg::point_out_t out_data
);
    import vgdh_pkg::*;

    back_state_t           state_reg, state_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic [PROBE_BITS-1:0] probes_reg, probes_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    job_t                  job_reg;
    point_out_t            out_reg;

    logic                  ram_we;
    logic [SLOT_BITS-1:0]  ram_addr;
    logic [ENTRY_BITS:0]   ram_wdata, ram_rdata;
    logic                  hit_empty, hit_match, exhausted;

    vgdh_ram #(.WIDTH(ENTRY_BITS + 1), .DEPTH(TABLE_SIZE)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign hit_empty = !ram_rdata[ENTRY_BITS];
    assign hit_match = ram_rdata[ENTRY_BITS-1:0] == job_reg.voxel;
    assign exhausted = probes_reg == PROBE_BITS'(TABLE_SIZE - 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_CLEAR: if (slot_reg == SLOT_BITS'(TABLE_SIZE - 1)) state_next = BS_IDLE;
            BS_IDLE:  if (job_valid) state_next = BS_READ;
            BS_READ:  state_next = BS_CHECK;
            BS_CHECK:
            begin
                if (hit_empty)
                    state_next = BS_EMIT;
                else if (hit_match || exhausted)
                    state_next = BS_IDLE;
                else
                    state_next = BS_READ;
            end
            BS_EMIT:  if (!out_valid || out_ready) state_next = BS_IDLE;
            default:  state_next = BS_IDLE;
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        job_ready   = (state_reg == BS_IDLE);
        ram_we      = 1'b0;
        ram_addr    = slot_reg;
        ram_wdata   = {1'b1, job_reg.voxel};
        slot_next   = slot_reg;
        probes_next = probes_reg;
        count_next  = count_reg;
        unique case (state_reg)
            BS_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                slot_next = slot_reg + 1'b1;
            end
            BS_IDLE:
            begin
                slot_next   = job.slot;
                probes_next = '0;
            end
            BS_READ: ;
            BS_CHECK:
            begin
                if (hit_empty)
                begin
                    ram_we = 1'b1;
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 1'b1;
                end
                else if (!hit_match && !exhausted)
                begin
                    slot_next   = slot_reg + job_reg.step;
                    probes_next = probes_reg + 1'b1;
                end
            end
            BS_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_CLEAR;
            slot_reg   <= '0;
            probes_reg <= '0;
            count_reg  <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            probes_reg <= probes_next;
            count_reg  <= count_next;
            if (state_reg == BS_EMIT && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // Latch request and result
    always_ff @(posedge clk)
    begin
        if (state_reg == BS_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == BS_EMIT && (!out_valid || out_ready))
        begin
            out_reg.kept_x        <= job_reg.px;
            out_reg.kept_y        <= job_reg.py;
            out_reg.kept_z        <= job_reg.pz;
            out_reg.packed_colour <= job_reg.colour;
            out_reg.voxels_kept   <= count_reg;
        end
    end

    assign out_data = out_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == BS_CLEAR || state_reg == BS_CHECK))
        else $error("table written outside clear or insert");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_EMIT |-> count_reg != '0)
        else $error("emit with empty count");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        probes_reg <= PROBE_BITS'(TABLE_SIZE - 1))
        else $error("probe count past table size");
endmodule
